[rtl/mwt_pkg.sv]
// Package for the microwave timer controller: configuration and result
// structs, mode encoding, key codes, display codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package mwt_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SEC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_THRESH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FINISH_SEC    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUICK_ADD_SEC = 2'd3;

  localparam logic [7:0] RST_TICKS_PER_SEC = 8'd100;
  localparam logic [7:0] RST_BLINK_THRESH  = 8'd50;
  localparam logic [2:0] RST_FINISH_SEC    = 3'd5;
  localparam logic [5:0] RST_QUICK_ADD_SEC = 6'd30;

  localparam logic [2:0] MAX_DIGITS = 3'd5;

  localparam logic [7:0] KEY_START = 8'h41;
  localparam logic [7:0] KEY_STOP  = 8'h42;
  localparam logic [7:0] KEY_QUICK = 8'h43;
  localparam logic [7:0] KEY_DOOR  = 8'h44;
  localparam logic [7:0] KEY_STAR  = 8'h2A;
  localparam logic [7:0] KEY_HASH  = 8'h23;
  localparam logic [7:0] KEY_0     = 8'h30;
  localparam logic [7:0] KEY_9     = 8'h39;

  localparam logic [2:0] DM_TIME  = 3'd0;
  localparam logic [2:0] DM_ZERO  = 3'd1;
  localparam logic [2:0] DM_FIN   = 3'd2;
  localparam logic [2:0] DM_BLANK = 3'd3;
  localparam logic [2:0] DM_DOOR  = 3'd4;

  localparam logic [2:0] LED_RUN_SET  = 3'b011;
  localparam logic [2:0] LED_RUN_MASK = 3'b110;
  localparam logic [2:0] LED_FINISH   = 3'b100;
  localparam logic [2:0] LED_LIGHT    = 3'b010;
  localparam logic [2:0] LED_OFF      = 3'b000;

  typedef enum logic [2:0] {
    M_INIT  = 3'd0,
    M_ENTRY = 3'd1,
    M_COOK  = 3'd2,
    M_PAUSE = 3'd3,
    M_FIN   = 3'd4,
    M_DOOR  = 3'd5
  } mode_t;

  typedef struct packed {
    logic [7:0] ticks_per_sec;
    logic [7:0] blink_thresh;
    logic [2:0] finish_sec;
    logic [5:0] quick_add_sec;
  } cfg_t;

  typedef struct packed {
    logic [2:0] display_mode;
    logic [6:0] minutes;
    logic [6:0] seconds;
    logic [2:0] leds;
  } res_t;

endpackage

[rtl/mwt_cfg_regs.sv]
// Configuration register file for the microwave timer controller.
// Depends on mwt_pkg.
`timescale 1ns / 1ps

module mwt_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mwt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mwt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output mwt_pkg::cfg_t                   cfg
);

  mwt_pkg::cfg_t cfg_r;
  mwt_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        mwt_pkg::CFG_TICKS_PER_SEC: cfg_nxt.ticks_per_sec = cfg_wdata;
        mwt_pkg::CFG_BLINK_THRESH:  cfg_nxt.blink_thresh  = cfg_wdata;
        mwt_pkg::CFG_FINISH_SEC:    cfg_nxt.finish_sec    = cfg_wdata[2:0];
        mwt_pkg::CFG_QUICK_ADD_SEC: cfg_nxt.quick_add_sec = cfg_wdata[5:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_sec <= mwt_pkg::RST_TICKS_PER_SEC;
      cfg_r.blink_thresh  <= mwt_pkg::RST_BLINK_THRESH;
      cfg_r.finish_sec    <= mwt_pkg::RST_FINISH_SEC;
      cfg_r.quick_add_sec <= mwt_pkg::RST_QUICK_ADD_SEC;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/mwt_ctrl.sv]
// Timer state and single-pass update for one tick: key decode, mode
// machine, time entry, quick add, countdown and display/LED result.
// Depends on mwt_pkg.
`timescale 1ns / 1ps

module mwt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic          key_valid,
  input  logic [7:0]    key_code,
  input  mwt_pkg::cfg_t cfg,
  output mwt_pkg::res_t res
);

  localparam logic [6:0] SEC_MAX  = 7'd59;
  localparam logic [6:0] MIN_CAP_COOK = 7'd59;
  localparam logic [6:0] MIN_CAP_ENTRY = 7'd99;
  localparam logic [2:0] DC_MAX   = 3'd7;

  typedef struct packed {
    logic [6:0] mn;
    logic [6:0] sc;
  } time_t;

  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [3:0] t;
    t = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (v >= 7'(i * 10)) t = 4'(i);
    end
    return t;
  endfunction

  function automatic logic [3:0] ones_of(input logic [6:0] v);
    logic [6:0] t10;
    t10 = {3'd0, tens_of(v)} * 7'd10;
    return 4'(v - t10);
  endfunction

  function automatic time_t add_quick(input time_t t, input logic [5:0] q,
                                      input logic [6:0] cap);
    logic [7:0] s;
    time_t r;
    r = t;
    s = {1'b0, t.sc} + {2'd0, q};
    if (s > {1'b0, SEC_MAX}) begin
      if (t.mn >= cap) begin
        r.sc = SEC_MAX;
      end else begin
        r.mn = t.mn + 7'd1;
        r.sc = 7'(s - 8'd60);
      end
    end else begin
      r.sc = s[6:0];
    end
    return r;
  endfunction

  mwt_pkg::mode_t mode_r, mode_nxt;
  time_t          tv_r, tv_nxt;
  logic [2:0]     dc_r, dc_nxt;
  logic [7:0]     tick_r, tick_nxt;
  logic [2:0]     fc_r, fc_nxt;
  logic           door_r, door_nxt;
  logic [2:0]     led_r, led_nxt;
  logic           pend_r, pend_nxt;

  logic           st, sp, clr, qk, num, early;
  logic [5:0]     qamt;
  logic [2:0]     dc_inc, dc_c;
  logic [7:0]     tick_inc;
  logic [3:0]     digit;
  logic [2:0]     dm;
  time_t          tc, tq;

  assign qamt     = (cfg.quick_add_sec > 6'd59) ? 6'd59 : cfg.quick_add_sec;
  assign dc_inc   = (dc_r == DC_MAX) ? dc_r : dc_r + 3'd1;
  assign tick_inc = tick_r + 8'd1;
  assign digit    = 4'(key_code - mwt_pkg::KEY_0);

  always_comb begin
    mode_nxt = mode_r;
    tv_nxt   = tv_r;
    dc_nxt   = dc_r;
    tick_nxt = tick_r;
    fc_nxt   = fc_r;
    door_nxt = door_r;
    led_nxt  = led_r;
    pend_nxt = pend_r;
    st    = 1'b0;
    sp    = 1'b0;
    clr   = 1'b0;
    qk    = 1'b0;
    num   = pend_r;
    early = 1'b0;
    dm    = mwt_pkg::DM_TIME;
    dc_c  = dc_r;
    tc    = tv_r;
    tq    = tv_r;

    if (key_valid) begin
      case (key_code)
        mwt_pkg::KEY_START: begin
          st  = 1'b1;
          num = 1'b0;
        end
        mwt_pkg::KEY_STOP: begin
          sp  = 1'b1;
          clr = 1'b1;
          num = 1'b0;
        end
        mwt_pkg::KEY_QUICK: begin
          qk  = 1'b1;
          num = 1'b0;
        end
        mwt_pkg::KEY_DOOR: begin
          sp       = 1'b1;
          door_nxt = !door_r;
          num      = 1'b0;
        end
        mwt_pkg::KEY_STAR, mwt_pkg::KEY_HASH: begin
          num = pend_r;
        end
        default: begin
          num = 1'b1;
          if (mode_r == mwt_pkg::M_DOOR || mode_r == mwt_pkg::M_COOK ||
              mode_r == mwt_pkg::M_PAUSE) begin
            pend_nxt = 1'b1;
            early    = 1'b1;
          end else if (key_code >= mwt_pkg::KEY_0 && key_code <= mwt_pkg::KEY_9) begin
            tv_nxt.mn = 7'({3'd0, ones_of(tv_r.mn)} * 7'd10) + {3'd0, tens_of(tv_r.sc)};
            tv_nxt.sc = 7'({3'd0, ones_of(tv_r.sc)} * 7'd10) + {3'd0, digit};
          end
        end
      endcase
    end

    if (!early) begin
      if (door_nxt) begin
        mode_nxt = mwt_pkg::M_DOOR;
        pend_nxt = num;
      end else begin
        unique case (mode_r)
          mwt_pkg::M_DOOR: begin
            mode_nxt = mwt_pkg::M_PAUSE;
          end
          mwt_pkg::M_INIT: begin
            fc_nxt = 3'd0;
            if (st && (tv_nxt.mn != 7'd0 || tv_nxt.sc != 7'd0)) begin
              mode_nxt = mwt_pkg::M_COOK;
            end else if (qk) begin
              tv_nxt.mn = 7'd0;
              tv_nxt.sc = {1'b0, qamt};
              mode_nxt  = mwt_pkg::M_COOK;
            end else if (num) begin
              mode_nxt = mwt_pkg::M_ENTRY;
              dc_nxt   = dc_inc;
            end
          end
          mwt_pkg::M_ENTRY: begin
            if (key_valid) begin
              if (st) begin
                mode_nxt = mwt_pkg::M_COOK;
              end else if (clr) begin
                tv_nxt   = '0;
                dc_nxt   = 3'd0;
                mode_nxt = mwt_pkg::M_INIT;
              end else if (num) begin
                if (!(tv_nxt.mn == 7'd0 && tv_nxt.sc == 7'd0 && dc_r == 3'd0)) begin
                  dc_c = dc_inc;
                end
                if (dc_c >= mwt_pkg::MAX_DIGITS) begin
                  dc_nxt = 3'd0;
                  tv_nxt = '0;
                end else begin
                  dc_nxt = dc_c;
                end
              end else if (qk) begin
                tv_nxt   = add_quick(tv_nxt, qamt, MIN_CAP_ENTRY);
                mode_nxt = mwt_pkg::M_COOK;
              end
            end
          end
          mwt_pkg::M_COOK: begin
            if (sp) begin
              mode_nxt = mwt_pkg::M_PAUSE;
            end else begin
              tc.mn = (tv_nxt.mn > MIN_CAP_COOK) ? MIN_CAP_COOK : tv_nxt.mn;
              tc.sc = (tv_nxt.sc > SEC_MAX) ? SEC_MAX : tv_nxt.sc;
              tq    = qk ? add_quick(tc, qamt, MIN_CAP_COOK) : tc;
              tv_nxt   = tq;
              tick_nxt = tick_inc;
              if (tick_inc >= cfg.ticks_per_sec) begin
                tick_nxt = 8'd0;
                if (tq.sc != 7'd0) begin
                  tv_nxt.sc = tq.sc - 7'd1;
                end else if (tq.mn != 7'd0) begin
                  tv_nxt.mn = tq.mn - 7'd1;
                  tv_nxt.sc = SEC_MAX;
                end
                if (tv_nxt.mn == 7'd0 && tv_nxt.sc == 7'd0) begin
                  mode_nxt = mwt_pkg::M_FIN;
                end
              end
            end
          end
          mwt_pkg::M_PAUSE: begin
            if (st) mode_nxt = mwt_pkg::M_COOK;
            if (num || clr) begin
              tv_nxt   = '0;
              dc_nxt   = 3'd0;
              mode_nxt = mwt_pkg::M_INIT;
            end
            if (qk) tv_nxt = add_quick(tv_nxt, qamt, MIN_CAP_ENTRY);
          end
          default: begin
            if (key_valid || fc_r == cfg.finish_sec) mode_nxt = mwt_pkg::M_INIT;
            if (tick_r >= cfg.ticks_per_sec) begin
              fc_nxt   = fc_r + 3'd1;
              tick_nxt = 8'd1;
            end else begin
              tick_nxt = tick_inc;
            end
          end
        endcase
        pend_nxt = 1'b0;
      end
    end

    unique case (mode_nxt)
      mwt_pkg::M_INIT: begin
        dm      = mwt_pkg::DM_ZERO;
        led_nxt = mwt_pkg::LED_OFF;
      end
      mwt_pkg::M_ENTRY: begin
        dm = mwt_pkg::DM_TIME;
      end
      mwt_pkg::M_COOK: begin
        dm      = mwt_pkg::DM_TIME;
        led_nxt = led_r | mwt_pkg::LED_RUN_SET;
      end
      mwt_pkg::M_PAUSE: begin
        dm      = mwt_pkg::DM_TIME;
        led_nxt = led_r & mwt_pkg::LED_RUN_MASK;
      end
      mwt_pkg::M_FIN: begin
        if (tick_nxt < cfg.blink_thresh) begin
          dm      = mwt_pkg::DM_FIN;
          led_nxt = mwt_pkg::LED_FINISH;
        end else begin
          dm      = mwt_pkg::DM_BLANK;
          led_nxt = mwt_pkg::LED_OFF;
        end
      end
      default: begin
        dm      = mwt_pkg::DM_DOOR;
        led_nxt = mwt_pkg::LED_LIGHT;
      end
    endcase

    res.display_mode = dm;
    res.minutes      = (dm == mwt_pkg::DM_TIME) ? tv_nxt.mn : 7'd0;
    res.seconds      = (dm == mwt_pkg::DM_TIME) ? tv_nxt.sc : 7'd0;
    res.leds         = led_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mwt_pkg::M_INIT;
      tv_r   <= '0;
      dc_r   <= 3'd0;
      tick_r <= 8'd0;
      fc_r   <= 3'd0;
      door_r <= 1'b0;
      led_r  <= 3'd0;
      pend_r <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt;
      tv_r   <= tv_nxt;
      dc_r   <= dc_nxt;
      tick_r <= tick_nxt;
      fc_r   <= fc_nxt;
      door_r <= door_nxt;
      led_r  <= led_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

[rtl/microwave_timer_controller.sv]
// Microwave timer controller top level: input register, tick update, result register.
// Each tick is held in the input register, then its result in the result register.
// One tick item per cycle while the result stage is not held by out_stall.
// Reset (rst_n low, synchronous): mode initial, time and counters zero, door
// closed, LEDs off, configuration at defaults, both stages empty.
// Depends on mwt_pkg, mwt_cfg_regs, mwt_ctrl.
`timescale 1ns / 1ps

module microwave_timer_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mwt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mwt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_key_valid,
  input  logic [7:0]                      in_key_code,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      out_display_mode,
  output logic [6:0]                      out_minutes,
  output logic [6:0]                      out_seconds,
  output logic [2:0]                      out_leds
);

  mwt_pkg::cfg_t cfg;
  mwt_pkg::res_t res;
  mwt_pkg::res_t res_r;

  logic       s1_valid_r, s1_valid_nxt;
  logic       key_valid_r;
  logic [7:0] key_code_r;
  logic       out_valid_r, out_valid_nxt;
  logic       s2_ready, step, in_xfer;

  assign s2_ready = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && s2_ready;
  assign in_stall = s1_valid_r && !s2_ready;
  assign in_xfer  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_xfer ? 1'b1 : (step ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s2_ready ? step : out_valid_r;

  mwt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mwt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .key_valid (key_valid_r),
    .key_code  (key_code_r),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      key_valid_r <= in_key_valid;
      key_code_r  <= in_key_code;
    end
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_display_mode = res_r.display_mode;
  assign out_minutes      = res_r.minutes;
  assign out_seconds      = res_r.seconds;
  assign out_leds         = res_r.leds;

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result stage can advance");

  a_time_blank_off_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_display_mode != mwt_pkg::DM_TIME)
      |-> (out_minutes == 7'd0 && out_seconds == 7'd0))
    else $error("time shown outside time display mode");

  a_time_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_minutes <= 7'd99 && out_seconds <= 7'd99))
    else $error("time field out of range");

  a_fin_led: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_display_mode == mwt_pkg::DM_FIN) |-> (out_leds == mwt_pkg::LED_FINISH))
    else $error("finish display without finish LED alone");
`endif

endmodule

[bench/tb.sv]
// Self-checking bench for microwave_timer_controller: predicts the display
// for every transferred tick and compares it with each result transfer.
// Depends on mwt_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb;

  localparam int ITEM_TARGET = 1550;
  localparam int HOLD_CYCLES = 150;
  localparam int WDOG_LIMIT  = 3000;

  typedef struct {
    logic       kv;
    logic [7:0] code;
  } tick_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [mwt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mwt_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           in_key_valid = 1'b0;
  logic [7:0]                     in_key_code = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [2:0]                     out_display_mode;
  logic [6:0]                     out_minutes;
  logic [6:0]                     out_seconds;
  logic [2:0]                     out_leds;

  microwave_timer_controller u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_key_valid     (in_key_valid),
    .in_key_code      (in_key_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_display_mode (out_display_mode),
    .out_minutes      (out_minutes),
    .out_seconds      (out_seconds),
    .out_leds         (out_leds)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tick_t         tick_q[$];
  mwt_pkg::res_t display_q[$];
  int    n_queued = 0;
  int    n_accepted = 0;
  int    n_checked = 0;
  int    n_err = 0;
  int    n_fin = 0;
  int    n_door = 0;
  int    n_phases = 1;
  int    snd_max = 18;
  int    rcv_max = 18;
  int    snd_wait = 0;
  int    rcv_wait = 0;
  int    idle_cyc = 0;
  bit    hold_req = 1'b0;
  bit    hold_done = 1'b0;

  // oven state and register copies
  mwt_pkg::mode_t oven_mode = mwt_pkg::M_INIT;
  int         oven_time = 0;
  int         digit_cnt = 0;
  int         tick_cnt = 0;
  int         fin_cnt = 0;
  bit         door_is_open = 1'b0;
  bit         digit_pending = 1'b0;
  logic [2:0] led_state = mwt_pkg::LED_OFF;
  int         cfg_tps = int'(mwt_pkg::RST_TICKS_PER_SEC);
  int         cfg_blink = int'(mwt_pkg::RST_BLINK_THRESH);
  int         cfg_fin = int'(mwt_pkg::RST_FINISH_SEC);
  int         cfg_quick = int'(mwt_pkg::RST_QUICK_ADD_SEC);

  function automatic int draw_gap(int mx);
    return $urandom_range(0, mx);
  endfunction

  function automatic int add_quick(int tv, int cap);
    int mn;
    int sc;
    mn = tv / 100;
    sc = tv % 100 + ((cfg_quick > 59) ? 59 : cfg_quick);
    if (sc > 59) begin
      if (mn >= cap) sc = 59;
      else begin
        mn++;
        sc -= 60;
      end
    end
    return mn * 100 + sc;
  endfunction

  function automatic mwt_pkg::res_t advance_oven(logic kv, logic [7:0] code);
    bit            st;
    bit            sp;
    bit            clr;
    bit            qk;
    bit            num;
    bit            held;
    int            mn;
    int            sc;
    logic [2:0]    dm;
    mwt_pkg::res_t r;
    st = 0; sp = 0; clr = 0; qk = 0; held = 0;
    num = digit_pending;
    if (kv) begin
      case (code)
        mwt_pkg::KEY_START: begin st = 1; num = 0; end
        mwt_pkg::KEY_STOP: begin sp = 1; clr = 1; num = 0; end
        mwt_pkg::KEY_QUICK: begin qk = 1; num = 0; end
        mwt_pkg::KEY_DOOR: begin sp = 1; door_is_open = !door_is_open; num = 0; end
        mwt_pkg::KEY_STAR, mwt_pkg::KEY_HASH: ;
        default: begin
          num = 1;
          if (oven_mode inside {mwt_pkg::M_DOOR, mwt_pkg::M_COOK, mwt_pkg::M_PAUSE}) begin
            digit_pending = 1;
            held = 1;
          end else if (code >= mwt_pkg::KEY_0 && code <= mwt_pkg::KEY_9) begin
            oven_time = (oven_time * 10 + int'(code - mwt_pkg::KEY_0)) % 10000;
          end
        end
      endcase
    end
    if (!held && door_is_open) begin
      oven_mode = mwt_pkg::M_DOOR;
      digit_pending = num;
    end else if (!held) begin
      case (oven_mode)
        mwt_pkg::M_DOOR: oven_mode = mwt_pkg::M_PAUSE;
        mwt_pkg::M_INIT: begin
          fin_cnt = 0;
          if (st && oven_time != 0) oven_mode = mwt_pkg::M_COOK;
          else if (qk) begin
            oven_time = (cfg_quick > 59) ? 59 : cfg_quick;
            oven_mode = mwt_pkg::M_COOK;
          end else if (num) begin
            oven_mode = mwt_pkg::M_ENTRY;
            if (digit_cnt < 7) digit_cnt++;
          end
        end
        mwt_pkg::M_ENTRY: begin
          if (kv) begin
            if (st) oven_mode = mwt_pkg::M_COOK;
            else if (clr) begin
              oven_time = 0;
              digit_cnt = 0;
              oven_mode = mwt_pkg::M_INIT;
            end else if (num) begin
              if (!(oven_time == 0 && digit_cnt == 0) && digit_cnt < 7) digit_cnt++;
              if (digit_cnt >= int'(mwt_pkg::MAX_DIGITS)) begin
                digit_cnt = 0;
                oven_time = 0;
              end
            end else if (qk) begin
              oven_time = add_quick(oven_time, 99);
              oven_mode = mwt_pkg::M_COOK;
            end
          end
        end
        mwt_pkg::M_COOK: begin
          if (sp) oven_mode = mwt_pkg::M_PAUSE;
          else begin
            mn = oven_time / 100;
            sc = oven_time % 100;
            if (mn > 59) mn = 59;
            if (sc > 59) sc = 59;
            oven_time = mn * 100 + sc;
            if (qk) oven_time = add_quick(oven_time, 59);
            tick_cnt = (tick_cnt + 1) & 255;
            if (tick_cnt >= cfg_tps) begin
              tick_cnt = 0;
              mn = oven_time / 100;
              sc = oven_time % 100;
              if (sc > 0) sc--;
              else if (mn > 0) begin
                mn--;
                sc = 59;
              end
              oven_time = mn * 100 + sc;
              if (oven_time == 0) oven_mode = mwt_pkg::M_FIN;
            end
          end
        end
        mwt_pkg::M_PAUSE: begin
          if (st) oven_mode = mwt_pkg::M_COOK;
          if (num || clr) begin
            oven_time = 0;
            digit_cnt = 0;
            oven_mode = mwt_pkg::M_INIT;
          end
          if (qk) oven_time = add_quick(oven_time, 99);
        end
        default: begin
          if (kv || fin_cnt == cfg_fin) oven_mode = mwt_pkg::M_INIT;
          if (tick_cnt >= cfg_tps) begin
            fin_cnt = (fin_cnt + 1) & 7;
            tick_cnt = 0;
          end
          tick_cnt = (tick_cnt + 1) & 255;
        end
      endcase
      digit_pending = 0;
    end
    case (oven_mode)
      mwt_pkg::M_INIT: begin dm = mwt_pkg::DM_ZERO; led_state = mwt_pkg::LED_OFF; end
      mwt_pkg::M_ENTRY: dm = mwt_pkg::DM_TIME;
      mwt_pkg::M_COOK: begin
        dm = mwt_pkg::DM_TIME;
        led_state = led_state | mwt_pkg::LED_RUN_SET;
      end
      mwt_pkg::M_PAUSE: begin
        dm = mwt_pkg::DM_TIME;
        led_state = led_state & mwt_pkg::LED_RUN_MASK;
      end
      mwt_pkg::M_FIN: begin
        if (tick_cnt < cfg_blink) begin
          dm = mwt_pkg::DM_FIN;
          led_state = mwt_pkg::LED_FINISH;
        end else begin
          dm = mwt_pkg::DM_BLANK;
          led_state = mwt_pkg::LED_OFF;
        end
      end
      default: begin dm = mwt_pkg::DM_DOOR; led_state = mwt_pkg::LED_LIGHT; end
    endcase
    mn = oven_time / 100;
    sc = oven_time % 100;
    r.display_mode = dm;
    r.minutes = (dm == mwt_pkg::DM_TIME) ? mn[6:0] : '0;
    r.seconds = (dm == mwt_pkg::DM_TIME) ? sc[6:0] : '0;
    r.leds = led_state;
    return r;
  endfunction

  task automatic report(string msg);
    n_err++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report($sformatf("result %0d %s got %0h want %0h", n_checked, name, got, want));
  endtask

  // input side: hold payload until transfer, then wait the drawn gap
  always @(posedge clk) begin : drive
    logic  free;
    tick_t cur;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_key_valid <= 1'b0;
      in_key_code <= '0;
      snd_wait <= 0;
    end else begin
      free = !in_valid;
      if (in_valid && !in_stall) begin
        display_q.push_back(advance_oven(in_key_valid, in_key_code));
        n_accepted++;
        free = 1'b1;
      end
      if (free) begin
        if (snd_wait > 0) begin
          snd_wait <= snd_wait - 1;
          in_valid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          cur = tick_q.pop_front();
          in_valid <= 1'b1;
          in_key_valid <= cur.kv;
          in_key_code <= cur.code;
          snd_wait <= draw_gap(snd_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : rcv_stall
    int w;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rcv_wait <= 0;
    end else begin
      w = rcv_wait;
      if (out_valid && !out_stall) w = draw_gap(rcv_max);
      if (hold_req && !hold_done) begin
        w = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        rcv_wait <= w - 1;
      end else begin
        out_stall <= 1'b0;
        rcv_wait <= 0;
      end
    end
  end

  always @(posedge clk) begin : watch_out
    mwt_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (display_q.size() == 0) begin
        report("result transfer with nothing expected");
      end else begin
        want = display_q.pop_front();
        check_field("display_mode", 8'(out_display_mode), 8'(want.display_mode));
        check_field("minutes", 8'(out_minutes), 8'(want.minutes));
        check_field("seconds", 8'(out_seconds), 8'(want.seconds));
        check_field("leds", 8'(out_leds), 8'(want.leds));
        if (want.display_mode == mwt_pkg::DM_FIN) n_fin++;
        if (want.display_mode == mwt_pkg::DM_DOOR) n_door++;
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= WDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WDOG_LIMIT);
      $display("tb: errors");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  task automatic push_tick(logic kv, logic [7:0] code);
    tick_t t;
    t.kv = kv;
    t.code = code;
    tick_q.push_back(t);
    n_queued++;
  endtask

  function automatic logic [7:0] rand_key();
    case ($urandom_range(0, 7))
      0: return mwt_pkg::KEY_START;
      1: return mwt_pkg::KEY_STOP;
      2: return mwt_pkg::KEY_QUICK;
      3: return mwt_pkg::KEY_DOOR;
      4: return mwt_pkg::KEY_STAR;
      5: return mwt_pkg::KEY_HASH;
      default: return 8'(mwt_pkg::KEY_0 + $urandom_range(0, 9));
    endcase
  endfunction

  task automatic push_noisy(int pct);
    if ($urandom_range(0, 99) < pct) push_tick(1'b1, rand_key());
    else push_tick(1'b0, 8'($urandom_range(0, 255)));
  endtask

  task automatic gen_episode();
    int kind;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) push_tick(1'b1, mwt_pkg::KEY_STOP);
    if (kind < 60) begin
      repeat (($urandom_range(0, 4) == 0) ? $urandom_range(3, 6) : $urandom_range(1, 2))
        push_tick(1'b1, 8'(mwt_pkg::KEY_0 + $urandom_range(0, 9)));
      push_tick(1'b1, ($urandom_range(0, 2) != 0) ? mwt_pkg::KEY_START : mwt_pkg::KEY_QUICK);
      repeat ($urandom_range(10, 120)) push_noisy(5);
    end else if (kind < 75) begin
      push_tick(1'b1, mwt_pkg::KEY_DOOR);
      repeat ($urandom_range(0, 4)) push_noisy(30);
      push_tick(1'b1, mwt_pkg::KEY_DOOR);
      repeat ($urandom_range(1, 10)) push_noisy(20);
    end else begin
      repeat ($urandom_range(5, 15))
        push_tick(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic write_reg(logic [mwt_pkg::CFG_IDX_W-1:0] idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[mwt_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    case (idx)
      mwt_pkg::CFG_TICKS_PER_SEC: cfg_tps = val;
      mwt_pkg::CFG_BLINK_THRESH: cfg_blink = val;
      mwt_pkg::CFG_FINISH_SEC: cfg_fin = val;
      default: cfg_quick = val;
    endcase
  endtask

  task automatic set_config(int tps, int blink, int fin, int quick);
    write_reg(mwt_pkg::CFG_TICKS_PER_SEC, tps);
    write_reg(mwt_pkg::CFG_BLINK_THRESH, blink);
    write_reg(mwt_pkg::CFG_FINISH_SEC, fin);
    write_reg(mwt_pkg::CFG_QUICK_ADD_SEC, quick);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drain();
    while (!(n_accepted == n_queued && display_q.size() == 0)) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    int target;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_tick(1'b0, 8'hFF);
    push_tick(1'b0, mwt_pkg::KEY_START);
    push_tick(1'b1, mwt_pkg::KEY_STAR);
    push_tick(1'b1, mwt_pkg::KEY_HASH);
    push_tick(1'b1, 8'h00);
    push_tick(1'b1, mwt_pkg::KEY_STOP);
    repeat (5) push_tick(1'b1, mwt_pkg::KEY_9);
    push_tick(1'b1, mwt_pkg::KEY_9);
    push_tick(1'b1, mwt_pkg::KEY_9);
    push_tick(1'b1, 8'(mwt_pkg::KEY_0 + 8'd5));
    push_tick(1'b1, mwt_pkg::KEY_9);
    push_tick(1'b1, mwt_pkg::KEY_QUICK);
    push_tick(1'b1, mwt_pkg::KEY_QUICK);
    push_tick(1'b1, mwt_pkg::KEY_DOOR);
    push_tick(1'b1, 8'(mwt_pkg::KEY_0 + 8'd5));
    push_tick(1'b1, mwt_pkg::KEY_DOOR);
    push_tick(1'b1, 8'(mwt_pkg::KEY_0 + 8'd7));
    push_tick(1'b0, 8'h00);
    push_tick(1'b1, mwt_pkg::KEY_QUICK);
    push_tick(1'b1, mwt_pkg::KEY_STOP);
    push_tick(1'b1, mwt_pkg::KEY_QUICK);
    push_tick(1'b1, mwt_pkg::KEY_START);
    wait_drain();

    for (int p = 1; n_queued < ITEM_TARGET; p++) begin
      case (p)
        1: set_config(1, 0, 1, 0);
        2: set_config(255, 255, 7, 59);
        3: set_config(2, 1, 3, 63);
        4: set_config(1, 255, 7, 60);
        default: set_config($urandom_range(1, 4),
                            ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 6),
                            $urandom_range(1, 7), $urandom_range(0, 63));
      endcase
      case (p % 3)
        0: begin snd_max = 0; rcv_max = 0; end
        1: begin snd_max = 18; rcv_max = 18; end
        default: begin snd_max = 18; rcv_max = 3; end
      endcase
      if (p == 3) hold_req = 1'b1;
      target = n_queued + ((p == 2) ? 300 : 160);
      if (target > ITEM_TARGET) target = ITEM_TARGET;
      while (n_queued < target) gen_episode();
      wait_drain();
      n_phases++;
    end

    if (display_q.size() != 0) report($sformatf("%0d results never arrived", display_q.size()));
    $display("summary: %0d ticks over %0d register settings, %0d results compared",
             n_accepted, n_phases, n_checked);
    $display("summary: finish message on %0d results, door message on %0d", n_fin, n_door);
    if (n_err == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

[filelist.f]
rtl/mwt_pkg.sv
rtl/mwt_cfg_regs.sv
rtl/mwt_ctrl.sv
rtl/microwave_timer_controller.sv
bench/tb.sv
